// ===== hw/rtl/i2cwm_pkg.sv =====
`default_nettype none

package i2cwm_pkg;

  // Default width of the per-phase tick counter and of the interval register.
  localparam int unsigned INTERVAL_BITS_DEF = 10;

  localparam logic [7:0] MSB_MASK      = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] RETRIES_RESET = 4'd5;
  localparam logic [7:0] COUNT_MAX     = 8'hFF;

  // Configuration register indexes.
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_ADDRESS  = 2'd1;
  localparam logic [1:0] REG_RETRIES  = 2'd2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_BYTE = 1'b1
  } op_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       last;
    logic       sda;
  } item_t;

  typedef enum logic [4:0] {
    PH_IDLE         = 5'd0,
    PH_START_HI     = 5'd1,
    PH_START_SDA_LO = 5'd2,
    PH_START_SCL_LO = 5'd3,
    PH_A_BIT_LOW    = 5'd4,
    PH_A_BIT_DATA   = 5'd5,
    PH_A_BIT_HIGH   = 5'd6,
    PH_A_ACK_LOW    = 5'd7,
    PH_A_ACK_WAIT   = 5'd8,
    PH_D_BIT_LOW    = 5'd9,
    PH_D_BIT_DATA   = 5'd10,
    PH_D_BIT_HIGH   = 5'd11,
    PH_D_ACK_LOW    = 5'd12,
    PH_D_ACK_WAIT   = 5'd13,
    PH_WAIT_BYTE    = 5'd14,
    PH_STOP_LOW     = 5'd15,
    PH_STOP_HIGH    = 5'd16,
    PH_STOP_SDA     = 5'd17
  } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cwm_in_if.sv =====
`default_nettype none

interface i2cwm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       sda_sample;

  modport source(output valid, kind, data_byte, last_byte, sda_sample, input ready);
  modport sink(input valid, kind, data_byte, last_byte, sda_sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2cwm_out_if.sv =====
`default_nettype none

interface i2cwm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_enable;
  logic       byte_taken;
  logic       ready_res;
  logic [7:0] acked_count;
  logic       done_res;

  modport source(output valid, scl_level, sda_level, sda_enable, byte_taken, ready_res,
                 acked_count, done_res, input ready);
  modport sink(input valid, scl_level, sda_level, sda_enable, byte_taken, ready_res,
               acked_count, done_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2c_write_master_top.sv =====
`default_nettype none
// An accepted request goes into the queue; the sequencer pops it and registers its
// result, which can then be taken. A tick or byte offer is one sequencer update.
// Throughput: one request per clock, as long as each result is taken when it appears.
// A two-entry queue keeps taking requests while a result waits to be taken.
// Reset (synchronous, active high) empties the queue, drops the result, returns
// the bus to idle with both lines high and loads the register defaults.

module i2c_write_master_top #(
  parameter int unsigned INTERVAL_BITS = i2cwm_pkg::INTERVAL_BITS_DEF,
  localparam int unsigned CfgW = (INTERVAL_BITS > 8) ? INTERVAL_BITS : 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  i2cwm_in_if.sink             item,
  i2cwm_out_if.source          result,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [CfgW-1:0] cfg_data
);
  import i2cwm_pkg::*;

  // Classified requests travel from the front through its queue to the
  // sequencer, which pops one whenever its output register can take a result.
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // The front accepts requests as long as its queue has room, so it only
  // stalls when the sequencer has been blocked by the result side for a while.
  i2cwm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // The sequencer holds the bus state, the configuration registers and the
  // result register. Each popped request is one full state update: ticks count
  // toward the end of a bus phase, and a byte offer starts a transaction or
  // continues one that is waiting for its next data byte; in other phases it is dropped.
  i2cwm_seq #(
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .result    (result)
  );

  // An accepted request is in the queue at the following edge at the latest.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> q_valid)
    else $error("accepted request did not reach the queue");

  // Finishing the stop condition leaves both lines high and the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.done_res |->
      result.scl_level && result.sda_level && result.ready_res)
    else $error("stop finished without an idle bus");

  // A byte that is taken always starts bus activity, so the block is busy.
  a_taken_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.byte_taken |-> !result.ready_res && !result.done_res)
    else $error("byte taken but block still reports waiting");

endmodule

`default_nettype wire

// ===== hw/rtl/i2cwm_front.sv =====
`default_nettype none

module i2cwm_front (
  input  wire logic           clk,
  input  wire logic           rst,
  i2cwm_in_if.sink            item,
  output i2cwm_pkg::item_t    q_item,
  output logic                q_valid,
  input  wire logic           q_pop
);
  import i2cwm_pkg::*;

  // Two-entry queue: the front keeps taking requests while the back is stalled.
  item_t       entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  item_t       classified;

  always_comb begin
    classified.op   = item.kind ? OP_BYTE : OP_TICK;
    classified.data = item.data_byte;
    classified.last = item.last_byte;
    classified.sda  = item.sda_sample;
  end

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign pop        = q_pop && q_valid;
  assign q_valid    = (count != 2'd0);
  assign q_item     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cwm_seq.sv =====
`default_nettype none

module i2cwm_seq #(
  parameter int unsigned INTERVAL_BITS = i2cwm_pkg::INTERVAL_BITS_DEF,
  localparam int unsigned CfgW = (INTERVAL_BITS > 8) ? INTERVAL_BITS : 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [CfgW-1:0] cfg_data,
  input  wire i2cwm_pkg::item_t q_item,
  input  wire logic            q_valid,
  output logic                 q_pop,
  i2cwm_out_if.source          result
);
  import i2cwm_pkg::*;

  localparam int unsigned IB = INTERVAL_BITS;

  logic [IB-1:0] interval_ticks;
  logic [7:0]    device_address;
  logic [3:0]    ack_retries;

  phase_t        phase, phase_next;
  logic [3:0]    bit_index, bit_index_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic [7:0]    pending_byte, pending_byte_next;
  logic [IB-1:0] tick_count, tick_count_next;
  logic [3:0]    retry_count, retry_count_next;
  logic [7:0]    ack_total, ack_total_next;
  logic          final_flag, final_flag_next;
  logic          clock_line, clock_line_next;
  logic          data_line, data_line_next;

  logic          take;
  logic          taken;
  logic          done;
  logic          is_data;
  logic          retry_left;
  logic          sda_en;
  logic [IB-1:0] limit;
  logic [IB:0]   tick_inc;
  logic [3:0]    bit_inc;

  logic          res_valid;

  assign take   = q_valid && (!res_valid || result.ready);
  assign q_pop  = take;
  assign limit  = (interval_ticks == '0) ? IB'(1) : interval_ticks;
  assign tick_inc = {1'b0, tick_count} + {{IB{1'b0}}, 1'b1};
  assign bit_inc  = bit_index + 4'd1;
  assign retry_left = (retry_count < ack_retries);
  assign is_data = (phase == PH_D_BIT_LOW) || (phase == PH_D_BIT_DATA) ||
                   (phase == PH_D_BIT_HIGH) || (phase == PH_D_ACK_LOW) ||
                   (phase == PH_D_ACK_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks <= IB'(1);
      device_address <= 8'd0;
      ack_retries    <= RETRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL: interval_ticks <= cfg_data[IB-1:0];
        REG_ADDRESS:  device_address <= cfg_data[7:0];
        REG_RETRIES:  ack_retries    <= cfg_data[3:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    pending_byte_next = pending_byte;
    tick_count_next   = tick_count;
    retry_count_next  = retry_count;
    ack_total_next    = ack_total;
    final_flag_next   = final_flag;
    clock_line_next   = clock_line;
    data_line_next    = data_line;
    taken             = 1'b0;
    done              = 1'b0;

    if (q_item.op == OP_BYTE) begin
      if (phase == PH_IDLE) begin
        pending_byte_next = q_item.data;
        final_flag_next   = q_item.last;
        ack_total_next    = 8'd0;
        clock_line_next   = 1'b1;
        data_line_next    = 1'b1;
        phase_next        = PH_START_HI;
        tick_count_next   = '0;
        taken             = 1'b1;
      end else if (phase == PH_WAIT_BYTE) begin
        final_flag_next = q_item.last;
        shift_byte_next = q_item.data;
        bit_index_next  = 4'd0;
        clock_line_next = 1'b0;
        phase_next      = PH_D_BIT_LOW;
        tick_count_next = '0;
        taken           = 1'b1;
      end
    end else if (phase != PH_IDLE && phase != PH_WAIT_BYTE) begin
      if (tick_inc >= {1'b0, limit}) begin
        // Every phase end enters a phase, which restarts the tick count.
        tick_count_next = '0;
        case (phase)
          PH_START_HI: begin
            data_line_next = 1'b0;
            phase_next     = PH_START_SDA_LO;
          end
          PH_START_SDA_LO: begin
            clock_line_next = 1'b0;
            phase_next      = PH_START_SCL_LO;
          end
          PH_START_SCL_LO: begin
            shift_byte_next = device_address;
            bit_index_next  = 4'd0;
            clock_line_next = 1'b0;
            phase_next      = PH_A_BIT_LOW;
          end
          PH_A_BIT_LOW, PH_D_BIT_LOW: begin
            data_line_next = |(shift_byte & MSB_MASK);
            phase_next     = is_data ? PH_D_BIT_DATA : PH_A_BIT_DATA;
          end
          PH_A_BIT_DATA, PH_D_BIT_DATA: begin
            clock_line_next = 1'b1;
            phase_next      = is_data ? PH_D_BIT_HIGH : PH_A_BIT_HIGH;
          end
          PH_A_BIT_HIGH, PH_D_BIT_HIGH: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_index_next  = bit_inc;
            clock_line_next = 1'b0;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_next = is_data ? PH_D_BIT_LOW : PH_A_BIT_LOW;
            end else begin
              phase_next = is_data ? PH_D_ACK_LOW : PH_A_ACK_LOW;
            end
          end
          PH_A_ACK_LOW, PH_D_ACK_LOW: begin
            clock_line_next  = 1'b1;
            retry_count_next = 4'd0;
            phase_next       = is_data ? PH_D_ACK_WAIT : PH_A_ACK_WAIT;
          end
          PH_A_ACK_WAIT, PH_D_ACK_WAIT: begin
            if (retry_left && q_item.sda) begin
              // Slave still holds off: one more interval with SCL low.
              retry_count_next = retry_count + 4'd1;
              clock_line_next  = 1'b0;
            end else if (!is_data) begin
              shift_byte_next = pending_byte;
              bit_index_next  = 4'd0;
              clock_line_next = 1'b0;
              phase_next      = PH_D_BIT_LOW;
            end else begin
              if (retry_left && ack_total != COUNT_MAX) begin
                ack_total_next = ack_total + 8'd1;
              end
              if (final_flag) begin
                clock_line_next = 1'b0;
                data_line_next  = 1'b0;
                phase_next      = PH_STOP_LOW;
              end else begin
                phase_next = PH_WAIT_BYTE;
              end
            end
          end
          PH_STOP_LOW: begin
            clock_line_next = 1'b1;
            phase_next      = PH_STOP_HIGH;
          end
          PH_STOP_HIGH: begin
            data_line_next = 1'b1;
            phase_next     = PH_STOP_SDA;
          end
          PH_STOP_SDA: begin
            done            = 1'b1;
            clock_line_next = 1'b1;
            data_line_next  = 1'b1;
            phase_next      = PH_IDLE;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end else begin
        tick_count_next = tick_inc[IB-1:0];
      end
    end

    // SDA is released while waiting for a byte, in acknowledge slots and in
    // the first low phase of a data byte.
    sda_en = !((phase_next == PH_WAIT_BYTE) ||
               (phase_next == PH_A_ACK_LOW) || (phase_next == PH_A_ACK_WAIT) ||
               (phase_next == PH_D_ACK_LOW) || (phase_next == PH_D_ACK_WAIT) ||
               ((phase_next == PH_D_BIT_LOW) && (bit_index_next == 4'd0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_index    <= 4'd0;
      shift_byte   <= 8'd0;
      pending_byte <= 8'd0;
      tick_count   <= '0;
      retry_count  <= 4'd0;
      ack_total    <= 8'd0;
      final_flag   <= 1'b0;
      clock_line   <= 1'b1;
      data_line    <= 1'b1;
    end else if (take) begin
      phase        <= phase_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      pending_byte <= pending_byte_next;
      tick_count   <= tick_count_next;
      retry_count  <= retry_count_next;
      ack_total    <= ack_total_next;
      final_flag   <= final_flag_next;
      clock_line   <= clock_line_next;
      data_line    <= data_line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.scl_level   <= clock_line_next;
      result.sda_level   <= sda_en && data_line_next;
      result.sda_enable  <= sda_en;
      result.byte_taken  <= taken;
      result.ready_res   <= (phase_next == PH_IDLE) || (phase_next == PH_WAIT_BYTE);
      result.acked_count <= ack_total_next;
      result.done_res    <= done;
    end
  end

  assign result.valid = res_valid;

endmodule

`default_nettype wire
